FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Checked during reset as well.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/clc_pkg.sv
// ----------------------------------------------------------------------------
// Card number check package
// Widths, pipeline sizes and result codes of the Luhn card number checker.
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int CARD_WIDTH     = 54;
    localparam int BCD_DIGITS     = 17;
    localparam int DIGIT_WIDTH    = 4;
    localparam int BCD_WIDTH      = BCD_DIGITS * DIGIT_WIDTH;
    localparam int CONV_WIDTH     = BCD_WIDTH + CARD_WIDTH;
    localparam int BITS_PER_STAGE = 6;
    localparam int CONV_STAGES    = CARD_WIDTH / BITS_PER_STAGE;
    localparam int COUNT_WIDTH    = 5;
    localparam int SUM_WIDTH      = 7;
    localparam int TOTAL_WIDTH    = 8;
    localparam int MAX_DIGITS     = 16;

    localparam int LEN_SHORT  = 13;
    localparam int LEN_MEDIUM = 15;
    localparam int LEN_LONG   = 16;

    typedef logic [DIGIT_WIDTH-1:0] t_digit;
    typedef t_digit [BCD_DIGITS-1:0] t_bcd;

    typedef enum logic [1:0] {
        VERDICT_INVALID    = 2'd0,
        VERDICT_AMEX       = 2'd1,
        VERDICT_VISA       = 2'd2,
        VERDICT_MASTERCARD = 2'd3
    } t_verdict;

endpackage

FILE: hw/rtl/card_number_luhn_check.sv
// ----------------------------------------------------------------------------
// Luhn card number checker
// Converts a binary card number to decimal, counts its digits, runs the
// Luhn mod-10 check; a valid card is branded from its two leading digits.
// ----------------------------------------------------------------------------
// The request channel carries one card number (i_card_number) under
// i_in_valid / o_in_ready; the result channel carries o_verdict,
// o_digit_count and o_checksum_ok under o_out_valid / i_out_ready.
// Each request yields exactly one result, in order.
// A request accepted at a clock edge passes through one input register,
// nine binary-to-decimal stages of six bits each, one digit-summing stage
// and the result register before its result shows.
// Throughput is one request per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; it rises again in the cycle the result is taken.
// A synchronous reset (i_rst_n low) empties the pipeline; no result is
// shown until new requests have passed through it.
// ----------------------------------------------------------------------------
module card_number_luhn_check #(
    parameter int MAX_DIGITS = clc_pkg::MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [clc_pkg::CARD_WIDTH-1:0] i_card_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_verdict,
    output logic [clc_pkg::COUNT_WIDTH-1:0] o_digit_count,
    output logic                          o_checksum_ok
);

    localparam int Stages = clc_pkg::CONV_STAGES;
    localparam int CardW  = clc_pkg::CARD_WIDTH;
    localparam int ConvW  = clc_pkg::CONV_WIDTH;
    localparam int Digits = clc_pkg::BCD_DIGITS;
    localparam int DigW   = clc_pkg::DIGIT_WIDTH;
    localparam int CntW   = clc_pkg::COUNT_WIDTH;
    localparam int SumW   = clc_pkg::SUM_WIDTH;
    localparam int TotW   = clc_pkg::TOTAL_WIDTH;
    localparam int Half   = (Digits + 1) / 2;

    function automatic logic [ConvW-1:0] dabble_steps(input logic [ConvW-1:0] v);
        logic [ConvW-1:0] s;
        s = v;
        for (int st = 0; st < clc_pkg::BITS_PER_STAGE; st++) begin
            for (int d = 0; d < Digits; d++) begin
                if (s[CardW + DigW*d +: DigW] >= DigW'(5)) begin
                    s[CardW + DigW*d +: DigW] = s[CardW + DigW*d +: DigW] + DigW'(3);
                end
            end
            s = s << 1;
        end
        return s;
    endfunction

    function automatic clc_pkg::t_digit luhn_map(input clc_pkg::t_digit d, input logic dbl);
        logic [DigW:0] twice;
        twice = {d, 1'b0};
        if (!dbl) begin
            return d;
        end else if (twice >= (DigW+1)'(10)) begin
            return DigW'(twice - (DigW+1)'(9));
        end else begin
            return DigW'(twice);
        end
    endfunction

    function automatic logic is_mult_of_ten(input logic [TotW-1:0] x);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * 10 < (1 << TotW); k++) begin
            if (x == TotW'(k * 10)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic clc_pkg::t_verdict brand_of(input clc_pkg::t_digit hi,
                                                   input clc_pkg::t_digit lo);
        priority if (hi == DigW'(3) && (lo == DigW'(4) || lo == DigW'(7))) begin
            return clc_pkg::VERDICT_AMEX;
        end else if (hi == DigW'(4)) begin
            return clc_pkg::VERDICT_VISA;
        end else if (hi == DigW'(5) && lo >= DigW'(1) && lo <= DigW'(5)) begin
            return clc_pkg::VERDICT_MASTERCARD;
        end else begin
            return clc_pkg::VERDICT_INVALID;
        end
    endfunction

    logic             w_advance;
    logic             r_in_valid;
    logic [CardW-1:0] r_card;
    logic             r_cv_valid [Stages];
    logic [ConvW-1:0] r_cv       [Stages];
    logic [ConvW-1:0] n_cv       [Stages];

    clc_pkg::t_bcd    w_bcd;
    logic [SumW-1:0]  n_sum_lo, n_sum_hi;
    logic [CntW-1:0]  n_count;
    clc_pkg::t_digit  n_lead_hi, n_lead_lo;

    logic             r_lu_valid;
    logic [SumW-1:0]  r_sum_lo, r_sum_hi;
    logic [CntW-1:0]  r_count;
    clc_pkg::t_digit  r_lead_hi, r_lead_lo;

    logic [TotW-1:0]   w_total;
    logic              n_checksum_ok;
    logic              w_len_ok;
    clc_pkg::t_verdict n_verdict;

    logic              r_out_valid;
    clc_pkg::t_verdict r_verdict;
    logic [CntW-1:0]   r_digit_count;
    logic              r_checksum_ok;

    assign w_advance  = ~r_out_valid | i_out_ready;
    assign o_in_ready = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_card <= i_card_number;
        end
    end

    for (genvar k = 0; k < Stages; k++) begin : g_conv
        if (k == 0) begin : g_first
            assign n_cv[k] = dabble_steps({{clc_pkg::BCD_WIDTH{1'b0}}, r_card});
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv_valid[k] <= 1'b0;
                end else if (w_advance) begin
                    r_cv_valid[k] <= r_in_valid;
                end
            end
        end else begin : g_rest
            assign n_cv[k] = dabble_steps(r_cv[k-1]);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv_valid[k] <= 1'b0;
                end else if (w_advance) begin
                    r_cv_valid[k] <= r_cv_valid[k-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_cv[k] <= n_cv[k];
            end
        end
    end

    assign w_bcd = clc_pkg::t_bcd'(r_cv[Stages-1][ConvW-1:CardW]);

    always_comb begin
        n_sum_lo  = '0;
        n_sum_hi  = '0;
        n_count   = '0;
        n_lead_hi = '0;
        n_lead_lo = '0;
        for (int d = 0; d < Digits; d++) begin
            if (d < Half) begin
                n_sum_lo = n_sum_lo + SumW'(luhn_map(w_bcd[d], d % 2 == 1));
            end else begin
                n_sum_hi = n_sum_hi + SumW'(luhn_map(w_bcd[d], d % 2 == 1));
            end
            if (w_bcd[d] != '0) begin
                n_count   = CntW'(d + 1);
                n_lead_hi = w_bcd[d];
                n_lead_lo = (d > 0) ? w_bcd[(d > 0) ? d - 1 : 0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lu_valid <= 1'b0;
        end else if (w_advance) begin
            r_lu_valid <= r_cv_valid[Stages-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_sum_lo  <= n_sum_lo;
            r_sum_hi  <= n_sum_hi;
            r_count   <= n_count;
            r_lead_hi <= n_lead_hi;
            r_lead_lo <= n_lead_lo;
        end
    end

    assign w_total       = TotW'(r_sum_lo) + TotW'(r_sum_hi);
    assign n_checksum_ok = is_mult_of_ten(w_total) && (r_count <= CntW'(MAX_DIGITS));
    assign w_len_ok      = (r_count == CntW'(clc_pkg::LEN_SHORT))
                        || (r_count == CntW'(clc_pkg::LEN_MEDIUM))
                        || (r_count == CntW'(clc_pkg::LEN_LONG));
    assign n_verdict     = (w_len_ok && n_checksum_ok) ? brand_of(r_lead_hi, r_lead_lo)
                                                       : clc_pkg::VERDICT_INVALID;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_lu_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_verdict     <= n_verdict;
            r_digit_count <= r_count;
            r_checksum_ok <= n_checksum_ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_digit_count = r_digit_count;
    assign o_checksum_ok = r_checksum_ok;

endmodule

FILE: hw/rtl/clc_checker.sv
// ----------------------------------------------------------------------------
// Card number checker assertions
// Port-level checks on the Luhn card number checker, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [1:0]                      o_verdict,
    input logic [clc_pkg::COUNT_WIDTH-1:0] o_digit_count,
    input logic                            o_checksum_ok
);

    logic [clc_pkg::COUNT_WIDTH+2:0] w_result;
    logic                            w_out_stall;
    logic                            w_branded;
    logic                            w_len_ok;

    assign w_result    = {o_verdict, o_digit_count, o_checksum_ok};
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_branded   = o_out_valid && (o_verdict != clc_pkg::VERDICT_INVALID);
    assign w_len_ok    = (o_digit_count == 5'(clc_pkg::LEN_SHORT))
                      || (o_digit_count == 5'(clc_pkg::LEN_MEDIUM))
                      || (o_digit_count == 5'(clc_pkg::LEN_LONG));

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(w_result))
    `ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `ASSERT_SAME(a_brand_needs_sum, i_clk, i_rst_n, w_branded, o_checksum_ok && w_len_ok)
    `ASSERT_SAME(a_count_range, i_clk, i_rst_n, o_out_valid, o_digit_count <= 5'(17))
    `ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n), !o_out_valid)

endmodule

bind card_number_luhn_check clc_checker u_clc_checker (.*);
